@@ src/pdb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_pkg
// shared types and codes for the porter-duff pixel blender
// ----------------------------------------------------------------------------
package pdb_pkg;

  localparam int PixelWidth = 32;
  localparam int ChanWidth  = 8;
  localparam int NumChans   = PixelWidth / ChanWidth;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 32;

  // rounded division by 255: (x * 65793 + 2^23) >> 24
  localparam int SumWidth    = 2 * ChanWidth + 1;
  localparam int ScaleWidth  = 34;
  localparam logic [ScaleWidth-1:0] ScaleMul   = ScaleWidth'(65793);
  localparam logic [ScaleWidth-1:0] ScaleRound = ScaleWidth'(1) << 23;
  localparam int ScaleShift  = 24;

  typedef enum logic [3:0] {
    MODE_CLEAR    = 4'd0,
    MODE_SRC      = 4'd1,
    MODE_DST      = 4'd2,
    MODE_SRC_OVER = 4'd3,
    MODE_DST_OVER = 4'd4,
    MODE_SRC_IN   = 4'd5,
    MODE_DST_IN   = 4'd6,
    MODE_SRC_OUT  = 4'd7,
    MODE_DST_OUT  = 4'd8,
    MODE_SRC_ATOP = 4'd9,
    MODE_DST_ATOP = 4'd10,
    MODE_XOR      = 4'd11
  } mode_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COMP_MODE         = 2'd0,
    REG_SOURCE_COLOR      = 2'd1,
    REG_SOURCE_FROM_INPUT = 2'd2
  } reg_idx_t;

  // load strobes for the lane stages
  typedef struct packed {
    logic mul_ld;
    logic scale_ld;
  } lane_adv_t;

endpackage : pdb_pkg
`default_nettype wire

@@ src/pdb_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_lane
// one color channel: k1*c1 + k2*c2, then rounded scale by 1/255
// ----------------------------------------------------------------------------
module pdb_lane (
  input  wire logic                       clk,
  input  wire pdb_pkg::lane_adv_t         adv,
  input  wire logic [pdb_pkg::ChanWidth-1:0] k1,
  input  wire logic [pdb_pkg::ChanWidth-1:0] c1,
  input  wire logic [pdb_pkg::ChanWidth-1:0] k2,
  input  wire logic [pdb_pkg::ChanWidth-1:0] c2,
  output logic      [pdb_pkg::ChanWidth-1:0] chan_out
);
  import pdb_pkg::*;

  logic [2*ChanWidth-1:0] prod1;
  logic [2*ChanWidth-1:0] prod2;
  logic [SumWidth-1:0]    sum;
  logic [ScaleWidth-1:0]  scaled;

  assign prod1  = k1 * c1;
  assign prod2  = k2 * c2;
  assign scaled = ScaleWidth'(sum) * ScaleMul + ScaleRound;

  always_ff @(posedge clk) begin
    if (adv.mul_ld) begin
      sum <= {1'b0, prod1} + {1'b0, prod2};
    end
    if (adv.scale_ld) begin
      // only the low byte of the scaled value survives
      chan_out <= scaled[ScaleShift +: ChanWidth];
    end
  end

endmodule : pdb_lane
`default_nettype wire

@@ src/porter_duff_pixel_blend.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// porter_duff_pixel_blend
// composites a premultiplied argb8888 source onto a destination pixel
// ----------------------------------------------------------------------------
// usage:
//   s_* stream carries one transaction per pixel: dest_pixel in tdata[31:0],
//   shaded_pixel in tdata[63:32]. m_* stream returns one result_pixel per
//   input transaction, in order.
//   cfg_we/cfg_index/cfg_data write comp_mode (0), source_color (1) and
//   source_from_input (2); write them only while no pixel is in flight.
// pipeline:
//   four register stages (coefficient select, channel multiply-add, scale by
//   1/255 with a constant multiply, word add into the output register);
//   one pixel per cycle while the output is not stalled.
// reset:
//   rst empties the pipeline and sets comp_mode to src, source_color to 0
//   and source_from_input to 0.
// stall:
//   when m_tready is low the held result stays in place; each stage keeps
//   loading while a stage ahead of it is empty, and s_tready falls only once
//   every stage holds a pixel.
// ----------------------------------------------------------------------------
module porter_duff_pixel_blend (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [pdb_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire logic [pdb_pkg::CfgDataWidth-1:0]    cfg_data,
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [2*pdb_pkg::PixelWidth-1:0]    s_tdata,  // dest_pixel, shaded_pixel
  // output stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [pdb_pkg::PixelWidth-1:0]      m_tdata   // result_pixel
);
  import pdb_pkg::*;

  // configuration registers
  mode_t                 comp_mode;
  logic [PixelWidth-1:0] source_color;
  logic                  source_from_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_mode         <= MODE_SRC;
      source_color      <= '0;
      source_from_input <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COMP_MODE:         comp_mode         <= mode_t'(cfg_data[3:0]);
        REG_SOURCE_COLOR:      source_color      <= cfg_data[PixelWidth-1:0];
        REG_SOURCE_FROM_INPUT: source_from_input <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline valids and stage readiness
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  assign r4 = !v4 || m_tready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // stage 1: pick source, coefficients and the word that the lanes add onto
  logic [PixelWidth-1:0] d_pix, s_pix;
  logic [ChanWidth-1:0]  sa, da, isa, ida;
  logic [ChanWidth-1:0]  k1_next, k2_next;
  logic [PixelWidth-1:0] p1_next, p2_next, base_next;

  assign d_pix = s_tdata[PixelWidth-1:0];
  assign s_pix = source_from_input ? s_tdata[2*PixelWidth-1:PixelWidth] : source_color;
  assign sa    = s_pix[PixelWidth-1 -: ChanWidth];
  assign da    = d_pix[PixelWidth-1 -: ChanWidth];
  assign isa   = ~sa;
  assign ida   = ~da;

  // zero coefficients scale to zero, so copy modes ride through the base word as-is
  always_comb begin
    k1_next   = '0;
    k2_next   = '0;
    p1_next   = '0;
    p2_next   = '0;
    base_next = '0;
    case (comp_mode)
      MODE_CLEAR: ;
      MODE_SRC: base_next = s_pix;
      MODE_DST: base_next = d_pix;
      MODE_SRC_OVER: begin
        base_next = s_pix; k1_next = isa; p1_next = d_pix;
      end
      MODE_DST_OVER: begin
        base_next = d_pix; k1_next = ida; p1_next = s_pix;
      end
      MODE_SRC_IN: begin
        k1_next = da; p1_next = s_pix;
      end
      MODE_DST_IN: begin
        k1_next = sa; p1_next = d_pix;
      end
      MODE_SRC_OUT: begin
        k1_next = ida; p1_next = s_pix;
      end
      MODE_DST_OUT: begin
        k1_next = isa; p1_next = d_pix;
      end
      MODE_SRC_ATOP: begin
        k1_next = da; p1_next = s_pix; k2_next = isa; p2_next = d_pix;
      end
      MODE_DST_ATOP: begin
        k1_next = sa; p1_next = d_pix; k2_next = ida; p2_next = s_pix;
      end
      MODE_XOR: begin
        k1_next = ida; p1_next = s_pix; k2_next = isa; p2_next = d_pix;
      end
      default: base_next = d_pix;
    endcase
  end

  logic [ChanWidth-1:0]  k1, k2;
  logic [PixelWidth-1:0] p1, p2, base1, base2, base3;

  always_ff @(posedge clk) begin
    if (r1 && s_tvalid) begin
      k1    <= k1_next;
      k2    <= k2_next;
      p1    <= p1_next;
      p2    <= p2_next;
      base1 <= base_next;
    end
    if (r2 && v1) base2 <= base1;
    if (r3 && v2) base3 <= base2;
  end

  // stages 2 and 3: per-channel multiply-add and scale
  lane_adv_t             adv;
  logic [PixelWidth-1:0] lin;

  assign adv.mul_ld   = r2 && v1;
  assign adv.scale_ld = r3 && v2;

  for (genvar c = 0; c < NumChans; c++) begin : g_lane
    pdb_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .k1       (k1),
      .c1       (p1[c*ChanWidth +: ChanWidth]),
      .k2       (k2),
      .c2       (p2[c*ChanWidth +: ChanWidth]),
      .chan_out (lin[c*ChanWidth +: ChanWidth])
    );
  end

  // stage 4: whole-word add, wraps so carries cross channels in the over modes
  always_ff @(posedge clk) begin
    if (r4 && v3) m_tdata <= base3 + lin;
  end

  assign m_tvalid = v4;

endmodule : porter_duff_pixel_blend
`default_nettype wire

@@ src/pdb_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_checker
// port-level checks on the pixel blender, bound to the top level
// ----------------------------------------------------------------------------
module pdb_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [pdb_pkg::PixelWidth-1:0]      m_tdata
);
  import pdb_pkg::*;

  // reset leaves the pipeline empty and open
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  // input only backs up when the output is stalled with a full pipe
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output stall");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // with no input and an open output throughout, the pipe drains
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) ##1
    (!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) |=> !m_tvalid)
    else $error("pipeline did not drain");

endmodule : pdb_checker

bind porter_duff_pixel_blend pdb_checker u_pdb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

@@ bench/pixel_blend_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_blend_checker
// watches the config port and both pixel streams of the porter-duff blender,
// works out the composited pixel for each input transaction and compares it
// with the result transactions in order
// ----------------------------------------------------------------------------
module pixel_blend_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [pdb_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  wire logic [pdb_pkg::CfgDataWidth-1:0]     cfg_data,
  input  wire logic                                 s_tvalid,
  input  wire logic                                 s_tready,
  input  wire logic [2*pdb_pkg::PixelWidth-1:0]     s_tdata,  // dest_pixel, shaded_pixel
  input  wire logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  input  wire logic [pdb_pkg::PixelWidth-1:0]       m_tdata,  // result_pixel
  output int                                        fail_count,
  output int                                        outstanding
);
  import pdb_pkg::*;

  localparam longint unsigned RecipMul   = 65793;
  localparam longint unsigned RecipRound = 64'd1 << 23;
  localparam int              RecipShift = 24;

  logic [3:0]            comp_mode;
  logic [PixelWidth-1:0] source_color;
  logic                  source_from_input;
  logic [PixelWidth-1:0] expected_pixels[$];

  // rounded x / 255, only the low byte survives
  function automatic logic [7:0] div255(input longint unsigned x);
    longint unsigned q;
    q = (x * RecipMul + RecipRound) >> RecipShift;
    return q[7:0];
  endfunction

  // per channel (k1 * p1 + k2 * p2) / 255
  function automatic logic [31:0] weigh_pair(input logic [7:0] k1, input logic [31:0] p1,
                                             input logic [7:0] k2, input logic [31:0] p2);
    logic [31:0]     r;
    longint unsigned acc;
    for (int c = 0; c < NumChans; c++) begin
      acc = longint'(k1) * longint'(p1[8*c +: 8]) + longint'(k2) * longint'(p2[8*c +: 8]);
      r[8*c +: 8] = div255(acc);
    end
    return r;
  endfunction

  function automatic logic [31:0] composite_pixel(input logic [3:0] mode,
                                                  input logic [31:0] src,
                                                  input logic [31:0] dst);
    logic [7:0] sa, da, isa, ida;
    sa  = src[31:24];
    da  = dst[31:24];
    isa = ~sa;
    ida = ~da;
    case (mode)
      MODE_CLEAR:    return '0;
      MODE_SRC:      return src;
      MODE_DST:      return dst;
      MODE_SRC_OVER: return src + weigh_pair(isa, dst, 8'd0, 32'd0);
      MODE_DST_OVER: return dst + weigh_pair(ida, src, 8'd0, 32'd0);
      MODE_SRC_IN:   return weigh_pair(da, src, 8'd0, 32'd0);
      MODE_DST_IN:   return weigh_pair(sa, dst, 8'd0, 32'd0);
      MODE_SRC_OUT:  return weigh_pair(ida, src, 8'd0, 32'd0);
      MODE_DST_OUT:  return weigh_pair(isa, dst, 8'd0, 32'd0);
      MODE_SRC_ATOP: return weigh_pair(da, src, isa, dst);
      MODE_DST_ATOP: return weigh_pair(sa, dst, ida, src);
      MODE_XOR:      return weigh_pair(ida, src, isa, dst);
      default:       return dst;  // unused codes pass the destination through
    endcase
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    logic [PixelWidth-1:0] want;
    logic [PixelWidth-1:0] src;
    if (rst) begin
      comp_mode         = MODE_SRC;
      source_color      = '0;
      source_from_input = 1'b0;
      expected_pixels.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        src = source_from_input ? s_tdata[63:32] : source_color;
        expected_pixels.push_back(composite_pixel(comp_mode, src, s_tdata[31:0]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("result_pixel: no transaction expected, actual %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata !== want) begin
            $error("result_pixel: expected %h, actual %h", want, m_tdata);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COMP_MODE:         comp_mode = cfg_data[3:0];
          REG_SOURCE_COLOR:      source_color = cfg_data;
          REG_SOURCE_FROM_INPUT: source_from_input = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule : pixel_blend_checker

@@ bench/tb_porter_duff_pixel_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_porter_duff_pixel_blend
// drives directed and random pixels through the blender under every mode and
// source setting, with random gaps and stalls on both streams; the checker
// beside the block predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_porter_duff_pixel_blend;
  import pdb_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int NumPhases    = 20;
  localparam int PhasePixels  = 100;
  localparam int LongHold     = 60;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CfgIdxWidth-1:0]   cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [2*PixelWidth-1:0]  s_tdata;  // dest_pixel, shaded_pixel
  logic                     m_tvalid;
  logic                     m_tready;
  logic [PixelWidth-1:0]    m_tdata;  // result_pixel

  int fail_count;
  int outstanding;
  int cycle_count    = 0;
  int tx_max_gap     = 0;
  int rx_max_stall   = 0;
  int rx_hold_cycles = 0;

  porter_duff_pixel_blend dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  pixel_blend_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall per transaction, plus an occasional long hold-off
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_tready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = $urandom_range(rx_max_stall, 0);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // all tasks start and end on a falling edge
  task automatic cfg_write(input reg_idx_t idx, input logic [CfgDataWidth-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic push_pixel(input logic [31:0] dest, input logic [31:0] shaded);
    int gap;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {shaded, dest};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // stop offering pixels and wait until every result is back
  task automatic drain();
    s_tvalid = 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(5, 0))
      0: p[31:24] = 8'hff;
      1: p[31:24] = 8'h00;
      2: p = ($urandom_range(1, 0) ? 32'hffffffff : 32'h0) ^ (32'h1 << $urandom_range(31, 0));
      3: begin
        // well-formed premultiplied: color channels not above alpha
        for (int c = 0; c < 3; c++) p[8*c +: 8] = $urandom_range(p[31:24], 0);
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    logic [31:0] color;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: reset settings first (src mode, constant black source)
    tx_max_gap   = 2;
    rx_max_stall = 2;
    push_pixel(32'hffffffff, 32'hffffffff);
    push_pixel(32'h00000000, 32'h00000000);
    drain();
    cfg_write(REG_SOURCE_FROM_INPUT, 32'd1);

    // every mode code, unused ones included
    for (int m = 0; m < 16; m++) begin
      drain();
      cfg_write(REG_COMP_MODE, 32'(m));
      push_pixel(32'hff7f01fe, 32'h80ffc040);
    end

    // color channels above alpha, summed to the largest value
    drain();
    cfg_write(REG_COMP_MODE, 32'(MODE_XOR));
    push_pixel(32'h00ffffff, 32'h00ffffff);
    drain();
    cfg_write(REG_COMP_MODE, 32'(MODE_SRC_ATOP));
    push_pixel(32'hffffffff, 32'h00ffffff);
    drain();
    cfg_write(REG_COMP_MODE, 32'(MODE_DST_ATOP));
    push_pixel(32'h00ffffff, 32'hffffffff);

    // over modes with carries across channels
    drain();
    cfg_write(REG_COMP_MODE, 32'(MODE_SRC_OVER));
    push_pixel(32'hffffffff, 32'h80ffffff);
    drain();
    cfg_write(REG_COMP_MODE, 32'(MODE_DST_OVER));
    push_pixel(32'h80ffffff, 32'hffffffff);

    // shaded pixel must be ignored with the constant source selected
    drain();
    cfg_write(REG_SOURCE_FROM_INPUT, 32'd0);
    cfg_write(REG_SOURCE_COLOR, 32'hc0804020);
    cfg_write(REG_COMP_MODE, 32'(MODE_SRC_IN));
    push_pixel(32'h80ff00ff, $urandom);

    // random phases, each with its own settings
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p % 5)
        0: color = 32'h00000000;
        1: color = 32'hffffffff;
        default: color = rand_pixel();
      endcase
      cfg_write(REG_COMP_MODE, 32'(p < 16 ? p : $urandom_range(15, 0)));
      cfg_write(REG_SOURCE_COLOR, color);
      cfg_write(REG_SOURCE_FROM_INPUT, 32'(p % 3 != 1));
      case (p % 4)
        0: begin tx_max_gap = 0; rx_max_stall = 0; end
        1: begin tx_max_gap = 8; rx_max_stall = 8; end
        2: begin tx_max_gap = 0; rx_max_stall = 8; end
        default: begin tx_max_gap = 8; rx_max_stall = 0; end
      endcase
      // fill the pipeline against a blocked result side
      if (p == 2 || p == 11) begin
        tx_max_gap     = 0;
        rx_hold_cycles = LongHold;
      end
      for (int n = 0; n < PhasePixels; n++) begin
        if (n == PhasePixels / 2 && p % 5 == 2) begin
          s_tvalid = 1'b0;
          wait (outstanding == 0);
          @(negedge clk);
        end
        push_pixel(rand_pixel(), rand_pixel());
      end
    end

    s_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb_porter_duff_pixel_blend

@@ filelist.f @@
src/pdb_pkg.sv
src/pdb_lane.sv
src/porter_duff_pixel_blend.sv
src/pdb_checker.sv
bench/pixel_blend_checker.sv
bench/tb_porter_duff_pixel_blend.sv
